### rtl/core/lptf_pkg.sv
// ----------------------------------------------------------------------------
// lptf_pkg
// Shared constants and control/status types of the tail framer core.
// ----------------------------------------------------------------------------
package lptf_pkg;

    localparam int MAX_FRAME_LEN = 64;
    localparam int ADDR_W        = $clog2(MAX_FRAME_LEN);
    localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [7:0] END_BYTE = 8'hAA;

    // controller to datapath
    typedef struct packed {
        logic              rx_en;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_last;
    } lptf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              frame_done;
        logic [ADDR_W-1:0] frame_len;
        logic              rd_space;
    } lptf_status_t;

endpackage

### rtl/core/lptf_ram.sv
// ----------------------------------------------------------------------------
// lptf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lptf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/lptf_ctrl.sv
// ----------------------------------------------------------------------------
// lptf_ctrl
// Receive / replay sequencer of the tail framer.
// ----------------------------------------------------------------------------
module lptf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lptf_pkg::lptf_status_t status,
    output lptf_pkg::lptf_cmd_t    cmd
);

    typedef enum logic {
        ST_RECV,
        ST_PLAY
    } state_t;

    state_t                      state_reg, state_next;
    logic [lptf_pkg::ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [lptf_pkg::ADDR_W-1:0] last_idx_reg, last_idx_next;

    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        last_idx_next = last_idx_reg;
        cmd.rx_en     = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_addr   = rd_idx_reg;
        cmd.rd_last   = (rd_idx_reg == last_idx_reg);
        unique case (state_reg)
            ST_RECV: begin
                cmd.rx_en = 1'b1;
                if (status.frame_done) begin
                    last_idx_next = status.frame_len;
                    rd_idx_next   = '0;
                    state_next    = ST_PLAY;
                end
            end
            ST_PLAY: begin
                cmd.rd_en = status.rd_space;
                if (status.rd_space) begin
                    if (cmd.rd_last) begin
                        state_next = ST_RECV;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_RECV;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RECV;
        end else begin
            state_reg <= state_next;
        end
        rd_idx_reg   <= rd_idx_next;
        last_idx_reg <= last_idx_next;
    end

endmodule

### rtl/core/lptf_dp.sv
// ----------------------------------------------------------------------------
// lptf_dp
// Frame store, fill counter and two-word output buffer of the tail framer.
// ----------------------------------------------------------------------------
module lptf_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lptf_pkg::lptf_cmd_t    cmd,
    output lptf_pkg::lptf_status_t status,
    input  logic                   s_tvalid,
    input  logic [7:0]             s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    logic [lptf_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [lptf_pkg::ADDR_W-1:0] len_reg, len_next;
    logic                        in_fire;
    logic                        store_full;
    logic                        ram_we;
    logic [7:0]                  ram_rdata;

    logic                        rd_vld_reg;
    logic                        rd_last_reg;
    logic [7:0]                  buf_data_reg [2];
    logic                        buf_last_reg [2];
    logic                        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                  buf_cnt_reg, buf_cnt_next;
    logic                        pop;
    logic [2:0]                  occupancy;

    assign in_fire    = cmd.rx_en && s_tvalid;
    assign store_full = (count_reg >= lptf_pkg::CNT_W'(lptf_pkg::MAX_FRAME_LEN));

    always_comb begin
        count_next        = count_reg;
        len_next          = len_reg;
        ram_we            = 1'b0;
        status.frame_done = 1'b0;
        if (in_fire) begin
            if (count_reg == '0) begin
                // length word, oversized ones are ignored
                if ({1'b0, s_tdata} <= 9'(lptf_pkg::MAX_FRAME_LEN - 1)) begin
                    ram_we     = 1'b1;
                    len_next   = s_tdata[lptf_pkg::ADDR_W-1:0];
                    count_next = lptf_pkg::CNT_W'(1);
                end
            end else if (store_full) begin
                count_next = '0;
            end else begin
                ram_we = 1'b1;
                if (s_tdata == lptf_pkg::END_BYTE
                        && count_reg[lptf_pkg::ADDR_W-1:0] == len_reg) begin
                    status.frame_done = 1'b1;
                    count_next        = '0;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    assign status.frame_len = len_reg;

    lptf_ram #(
        .WIDTH (8),
        .DEPTH (lptf_pkg::MAX_FRAME_LEN)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[lptf_pkg::ADDR_W-1:0]),
        .wdata (s_tdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_rdata)
    );

    // reads in flight plus buffered words never exceed the buffer depth
    assign pop       = m_tvalid && m_tready;
    assign occupancy = {1'b0, buf_cnt_reg} + {2'b00, rd_vld_reg} - {2'b00, pop};
    assign status.rd_space = (occupancy < 3'd2);

    always_comb begin
        buf_cnt_next = buf_cnt_reg;
        case ({rd_vld_reg, pop})
            2'b10:   buf_cnt_next = buf_cnt_reg + 1'b1;
            2'b01:   buf_cnt_next = buf_cnt_reg - 1'b1;
            default: buf_cnt_next = buf_cnt_reg;
        endcase
    end

    assign m_tvalid = (buf_cnt_reg != 2'd0);
    assign m_tdata  = buf_data_reg[rd_ptr_reg];
    assign m_tlast  = buf_last_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            buf_cnt_reg <= 2'd0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
        end else begin
            count_reg   <= count_next;
            rd_vld_reg  <= cmd.rd_en;
            buf_cnt_reg <= buf_cnt_next;
            if (rd_vld_reg) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
        len_reg     <= len_next;
        rd_last_reg <= cmd.rd_last;
        if (rd_vld_reg) begin
            buf_data_reg[wr_ptr_reg] <= ram_rdata;
            buf_last_reg[wr_ptr_reg] <= rd_last_reg;
        end
    end

endmodule

### rtl/core/length_prefixed_tail_framer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_tail_framer_core
// Collects length-prefixed frames closed by an end word and replays them.
// ----------------------------------------------------------------------------
// s_ channel carries received words, one per handshake. The first word of a
// frame is its length L (L above 63 is skipped); once L words are held and
// the next word is 0xAA, the frame of L+1 words goes out on the m_ channel
// with m_tlast on the end word.
// While receiving, a word is taken every cycle. The word that closes a frame
// starts replay: the first output word passes the state register, the
// registered read port of the frame store and the output buffer, then one
// word per cycle follows as long as m_tready stays high. s_tready is low
// while the store is read out and rises again while the last two words may
// still sit in the output buffer.
// A stalled receiver holds the current word; reads stop once two words are
// buffered and resume as soon as it takes one.
// Reset empties the fill count and the output buffer; the store contents
// are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module length_prefixed_tail_framer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    lptf_pkg::lptf_cmd_t    cmd;
    lptf_pkg::lptf_status_t status;

    assign s_tready = cmd.rx_en;

    lptf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    lptf_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### verif/tb_length_prefixed_tail_framer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_tail_framer_core
// Self-checking bench for the length-prefixed tail framer core.
// ----------------------------------------------------------------------------
// Bytes go in on the s_ stream; a scoreboard keeps its own copy of the frame
// store and fill count and queues the words that each completed frame should
// replay. Every word taken from the m_ stream is checked in order, data and
// last mark. Directed frames cover the length extremes, skipped lengths, the
// zero length, store overflow and end bytes in the payload; random traffic
// follows under bursty input and several output stall patterns.
// ----------------------------------------------------------------------------
module tb_length_prefixed_tail_framer_core;

    localparam int CLK_HALF    = 5;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_WORDS  = 140;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_word_t;

    class frame_scoreboard;
        logic [7:0]                 frame_store [lptf_pkg::MAX_FRAME_LEN];
        logic [lptf_pkg::CNT_W-1:0] fill_count;
        frame_word_t                replay_q [$];
        int                         errors;
        int                         frames_done;
        int                         words_checked;
        int                         lengths_skipped;
        int                         overflows;

        function new();
            fill_count      = '0;
            errors          = 0;
            frames_done     = 0;
            words_checked   = 0;
            lengths_skipped = 0;
            overflows       = 0;
        endfunction

        function void note_input(logic [7:0] b);
            int k;
            if (fill_count == 0) begin
                if (b > lptf_pkg::MAX_FRAME_LEN - 1) begin
                    lengths_skipped++;
                end else begin
                    frame_store[0] = b;
                    fill_count     = lptf_pkg::CNT_W'(1);
                end
            end else if (fill_count >= lptf_pkg::MAX_FRAME_LEN) begin
                // full store: this word is dropped and a new length follows
                fill_count = '0;
                overflows++;
            end else begin
                frame_store[fill_count[lptf_pkg::ADDR_W-1:0]] = b;
                fill_count = fill_count + 1'b1;
                if (b == lptf_pkg::END_BYTE && frame_store[0] + 1 == fill_count) begin
                    for (k = 0; k < fill_count; k++)
                        replay_q.push_back({frame_store[k[lptf_pkg::ADDR_W-1:0]],
                                            k == fill_count - 1});
                    fill_count = '0;
                    frames_done++;
                end
            end
        endfunction

        function void check_result(logic [7:0] data, logic last);
            frame_word_t want;
            if (replay_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual data %02h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            want = replay_q.pop_front();
            words_checked++;
            if (want.data !== data) begin
                $display("%0t: data mismatch: expected %02h, actual %02h",
                         $time, want.data, data);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: tlast mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return replay_q.size();
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;

    frame_scoreboard sb = new();

    int words_sent = 0;
    int burst_left = 0;
    int pacing_on  = 0;
    int rx_mode    = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int rx_tick    = 0;

    length_prefixed_tail_framer_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: stall pattern per mode, plus long hold-offs on request
    always @(posedge aclk) begin
        rx_tick = rx_tick + 1;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ((rx_tick % 8) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic put_word(input logic [7:0] b);
        if (pacing_on != 0 && burst_left == 0) begin
            idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_input(b);
        words_sent++;
    endtask

    function automatic logic [7:0] payload_byte();
        if ($urandom_range(0, 9) == 0)
            return lptf_pkg::END_BYTE;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == lptf_pkg::END_BYTE);
        return b;
    endfunction

    task automatic send_frame(input int len);
        int i;
        put_word(len[7:0]);
        for (i = 1; i < len; i++)
            put_word(payload_byte());
        put_word(lptf_pkg::END_BYTE);
    endtask

    // finish whatever frame is open: close it if still possible, else overflow
    task automatic drain_partial_frame();
        int target;
        while (sb.fill_count != 0) begin
            target = int'(sb.frame_store[0]);
            if (target >= 1 && sb.fill_count == target)
                put_word(lptf_pkg::END_BYTE);
            else
                put_word(filler_byte());
        end
    endtask

    // stop offering the last word before waiting on the replay
    task automatic wait_replay_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic random_traffic(input int words);
        int stop_at;
        int pick;
        int len;
        int i;
        stop_at = words_sent - sb.lengths_skipped + words;
        while (words_sent - sb.lengths_skipped < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 6) == 0)
                    len = $urandom_range(13, lptf_pkg::MAX_FRAME_LEN - 1);
                else
                    len = $urandom_range(1, 12);
                send_frame(len);
            end else if (pick < 78) begin
                put_word(8'($urandom_range(lptf_pkg::MAX_FRAME_LEN, 255)));
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) put_word(8'($urandom));
                drain_partial_frame();
            end else begin
                // truncated frame: end byte arrives early and is kept as data
                len = $urandom_range(4, 20);
                put_word(len[7:0]);
                for (i = 0; i < $urandom_range(0, len - 3); i++)
                    put_word(filler_byte());
                put_word(lptf_pkg::END_BYTE);
                drain_partial_frame();
            end
        end
    endtask

    initial begin
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: skipped lengths, smallest frames, end byte in payload
        put_word(8'd64);
        put_word(8'hFF);
        put_word(8'd1);
        put_word(lptf_pkg::END_BYTE);
        put_word(8'd2);
        put_word(8'h00);
        put_word(lptf_pkg::END_BYTE);
        put_word(8'd3);
        put_word(lptf_pkg::END_BYTE);
        put_word(8'hFF);
        put_word(lptf_pkg::END_BYTE);

        // zero length fills the store, the next word is dropped
        put_word(8'd0);
        for (i = 1; i < lptf_pkg::MAX_FRAME_LEN; i++)
            put_word(filler_byte());
        put_word(lptf_pkg::END_BYTE);
        send_frame(5);

        // missed end position, then overflow and resync
        put_word(8'd10);
        for (i = 0; i < 10; i++)
            put_word(filler_byte());
        drain_partial_frame();

        // largest frame
        send_frame(lptf_pkg::MAX_FRAME_LEN - 1);
        wait_replay_done();

        // random traffic in segments with different pacing
        pacing_on = 1;
        rx_mode   = 1;
        random_traffic(RAND_WORDS / 4);

        // sender waits for every frame to drain before going on
        wait_replay_done();
        rx_mode = 2;
        random_traffic(RAND_WORDS / 4);

        // long receiver hold-off while frames keep coming
        pacing_on = 0;
        hold_req  = hold_req + 1;
        send_frame(20);
        send_frame(6);
        repeat (10) put_word(filler_byte());
        drain_partial_frame();

        pacing_on = 1;
        rx_mode   = 3;
        random_traffic(RAND_WORDS / 4);
        pacing_on = 0;
        rx_mode   = 0;
        random_traffic(RAND_WORDS / 4);

        idle_sender(1);
        wait_replay_done();
        repeat (4 * lptf_pkg::MAX_FRAME_LEN) @(posedge aclk);

        $display("run: %0d words in, %0d frames replayed as %0d words checked",
                 words_sent, sb.frames_done, sb.words_checked);
        $display("     %0d oversized lengths skipped, %0d store overflows",
                 sb.lengths_skipped, sb.overflows);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### length_prefixed_tail_framer_core.f
rtl/core/lptf_pkg.sv
rtl/core/lptf_ram.sv
rtl/core/lptf_ctrl.sv
rtl/core/lptf_dp.sv
rtl/core/length_prefixed_tail_framer_core.sv
verif/tb_length_prefixed_tail_framer_core.sv
